>>> hdl/msfl_pkg.sv
package msfl_pkg;

    localparam int unsigned STACK_COUNT_DEF = 4;
    localparam int unsigned SLOT_COUNT_DEF  = 16;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

>>> hdl/multi_stack_shared_free_list_unit.sv
// An accepted request passes through the input register, then the result register; throughput is
// one request per cycle when out_stall is low, each reading a stack top, a link and the free head.
// Stall on the result side holds the result register and backs up into the input register.
// Reset (rst_n low, asynchronous) empties every stack, chains all slots into the free list
// from slot zero upward and drops any transaction in flight; slot values stay unset.
module multi_stack_shared_free_list_unit #(
    parameter int unsigned STACK_COUNT = msfl_pkg::STACK_COUNT_DEF,
    parameter int unsigned SLOT_COUNT  = msfl_pkg::SLOT_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [1:0]         stack_id,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] pop_value,
    output logic               store_full
);

    localparam int PTR_W     = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W     = $clog2(SLOT_COUNT);
    localparam int SID_W     = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
    localparam int SID_EXT_W = (SID_W > 2) ? SID_W : 2;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOT_COUNT);

    logic               in_valid_reg, in_valid_next;
    logic               req_type_reg;
    logic [1:0]         stack_id_reg;
    logic signed [31:0] push_value_reg;

    logic               out_valid_reg, out_valid_next;
    msfl_pkg::status_t  status_reg, status_next;
    logic signed [31:0] pop_value_reg, pop_value_next;
    logic               store_full_reg, store_full_next;

    logic [PTR_W-1:0]   links_reg [SLOT_COUNT];
    logic [31:0]        values_reg [SLOT_COUNT];
    logic [PTR_W-1:0]   tops_reg [STACK_COUNT];
    logic [PTR_W-1:0]   free_head_reg, free_head_next;

    logic                 accept;
    logic                 advance;
    logic [SID_EXT_W-1:0] sid_ext;
    logic [SID_W-1:0]     sid_idx;
    logic                 sid_ok;
    logic [PTR_W-1:0]     top_cur;
    logic                 free_ok;
    logic                 top_ok;
    logic [IDX_W-1:0]     fh_idx;
    logic [IDX_W-1:0]     top_idx;
    logic                 push_go;
    logic                 pop_go;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign sid_ext = SID_EXT_W'(stack_id_reg);
    assign sid_idx = sid_ext[SID_W-1:0];
    assign sid_ok  = 32'(stack_id_reg) < 32'(STACK_COUNT);
    assign top_cur = tops_reg[sid_idx];
    assign free_ok = free_head_reg < NULL_PTR;
    assign top_ok  = top_cur < NULL_PTR;
    assign fh_idx  = free_head_reg[IDX_W-1:0];
    assign top_idx = top_cur[IDX_W-1:0];

    assign push_go = advance && (req_type_reg == msfl_pkg::REQ_PUSH) && sid_ok && free_ok;
    assign pop_go  = advance && (req_type_reg == msfl_pkg::REQ_POP) && sid_ok && top_ok;

    always_comb
    begin
        free_head_next = free_head_reg;
        if (push_go)
        begin
            free_head_next = links_reg[fh_idx];
        end
        else if (pop_go)
        begin
            free_head_next = top_cur;
        end
    end

    always_comb
    begin
        status_next     = msfl_pkg::ST_DONE;
        pop_value_next  = '0;
        store_full_next = !(free_head_next < NULL_PTR);
        case (req_type_reg)
            msfl_pkg::REQ_PUSH:
            begin
                if (!push_go)
                begin
                    status_next = msfl_pkg::ST_FULL;
                end
            end
            msfl_pkg::REQ_POP:
            begin
                if (pop_go)
                begin
                    pop_value_next = values_reg[top_idx];
                end
                else
                begin
                    status_next = msfl_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                status_next = msfl_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            free_head_reg <= '0;
            for (int i = 0; i < int'(SLOT_COUNT); i++)
            begin
                links_reg[i] <= PTR_W'(i + 1);
            end
            for (int j = 0; j < int'(STACK_COUNT); j++)
            begin
                tops_reg[j] <= NULL_PTR;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            free_head_reg <= free_head_next;
            if (push_go)
            begin
                links_reg[fh_idx] <= top_cur;
                tops_reg[sid_idx] <= free_head_reg;
            end
            else if (pop_go)
            begin
                links_reg[top_idx] <= free_head_reg;
                tops_reg[sid_idx]  <= links_reg[top_idx];
            end
        end
    end

    // hold payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg   <= req_type;
            stack_id_reg   <= stack_id;
            push_value_reg <= push_value;
        end
        if (advance)
        begin
            status_reg     <= status_next;
            pop_value_reg  <= pop_value_next;
            store_full_reg <= store_full_next;
        end
        if (push_go)
        begin
            values_reg[fh_idx] <= push_value_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign pop_value  = pop_value_reg;
    assign store_full = store_full_reg;

    a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NULL_PTR)
        else $error("free head beyond null marker");

    a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != msfl_pkg::ST_DONE) |-> pop_value_reg == 32'sd0)
        else $error("failed request carries a pop value");

    a_pop_frees_top: assert property (@(posedge clk) disable iff (!rst_n)
        pop_go |=> free_head_reg == $past(top_cur))
        else $error("pop did not return its slot to the free list");

    a_push_takes_head: assert property (@(posedge clk) disable iff (!rst_n)
        push_go |=> tops_reg[$past(sid_idx)] == $past(free_head_reg))
        else $error("push did not take the free head");

    a_drop_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !push_go && !pop_go |=> $stable(free_head_reg))
        else $error("failed request changed the free list");

endmodule
